FILE: rtl/core/apu_pkg.sv
// Shared types, constants and register codes of the Adam parameter update core.
package apu_pkg;

	// Parameter vector
	localparam int NUM_ELEMENTS = 1024;
	localparam int IDX_W = 10;

	// Fixed-point constants
	localparam logic [24:0] ONE_Q24 = 25'h100_0000;
	localparam logic [23:0] HALF_Q24 = 24'h80_0000;
	localparam logic [23:0] POWER_RST = 24'hFF_FFFF;

	// Configuration registers: codes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA1 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EPS = 2'd2;
	localparam int CFG_DATA_W = 24;
	localparam logic [23:0] BETA1_RST = 24'd15099494;
	localparam logic [23:0] BETA2_RST = 24'd16760439;
	localparam logic [15:0] EPS_RST = 16'd1;

	// Pipelined divider: 88-bit dividend, 33-bit divisor, 64 quotient bits
	localparam int DIV_NUM_W = 88;
	localparam int DIV_DEN_W = 33;
	localparam int DIV_Q_W = 64;

	// Pipelined square root: 64-bit radicand, 32-bit root
	localparam int SQRT_IN_W = 64;
	localparam int SQRT_OUT_W = 32;

	typedef struct packed {
		logic [23:0] beta1;
		logic [23:0] beta2;
		logic [15:0] eps;
	} cfg_t;

	// Per-element values that travel beside the arithmetic units
	typedef struct packed {
		logic [31:0] coef;
		logic [23:0] alpha;
		logic [IDX_W-1:0] idx;
		logic neg;
		logic [31:0] mag;
		logic dzero;
	} side_t;

	// Result of the moment update stage
	typedef struct packed {
		logic valid;
		logic [31:0] m;
		logic [63:0] v;
		logic [24:0] c1;
		logic [24:0] c2;
		logic [31:0] coef;
		logic [23:0] alpha;
		logic [IDX_W-1:0] idx;
	} mom_t;

endpackage

FILE: rtl/core/apu_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module apu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Write port and registered read, old data on a collision.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/apu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data carried along.
module apu_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  apu_pkg::side_t                     in_side,
	input  logic [apu_pkg::DIV_NUM_W-1:0]      num,
	input  logic [apu_pkg::DIV_DEN_W-1:0]      den,
	output logic                               out_valid,
	output apu_pkg::side_t                     out_side,
	output logic [apu_pkg::DIV_Q_W-1:0]        quo,
	output logic                               ovf
);
	import apu_pkg::*;

	logic                 valid_q [0:DIV_Q_W];
	side_t                side_q  [0:DIV_Q_W];
	logic [DIV_DEN_W-1:0] rem_q   [0:DIV_Q_W];
	logic [DIV_DEN_W-1:0] den_q   [0:DIV_Q_W];
	logic [DIV_Q_W-1:0]   num_q   [0:DIV_Q_W];
	logic [DIV_Q_W-1:0]   quo_q   [0:DIV_Q_W];
	logic                 ovf_q   [0:DIV_Q_W];

	logic [DIV_DEN_W-1:0] rem_n [0:DIV_Q_W-1];
	logic                 bit_n [0:DIV_Q_W-1];

	// One trial subtraction per stage.
	always_comb begin
		logic [DIV_DEN_W:0] trial;
		logic [DIV_DEN_W:0] diff;
		for (int k = 0; k < DIV_Q_W; k++) begin
			trial = {rem_q[k], num_q[k][DIV_Q_W-1]};
			diff = trial - {1'b0, den_q[k]};
			bit_n[k] = (trial >= {1'b0, den_q[k]});
			rem_n[k] = bit_n[k] ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_Q_W; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else if (en) begin
			valid_q[0] <= in_valid;
			for (int k = 0; k < DIV_Q_W; k++) begin
				valid_q[k+1] <= valid_q[k];
			end
		end
	end

	// Stage data: the high dividend bits seed the remainder, the rest shift in.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
			ovf_q[0] <= (DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den);
			num_q[0] <= num[DIV_Q_W-1:0];
			den_q[0] <= den;
			quo_q[0] <= '0;
			side_q[0] <= in_side;
			for (int k = 0; k < DIV_Q_W; k++) begin
				rem_q[k+1] <= rem_n[k];
				ovf_q[k+1] <= ovf_q[k];
				num_q[k+1] <= {num_q[k][DIV_Q_W-2:0], 1'b0};
				den_q[k+1] <= den_q[k];
				quo_q[k+1] <= {quo_q[k][DIV_Q_W-2:0], bit_n[k]};
				side_q[k+1] <= side_q[k];
			end
		end
	end

	assign out_valid = valid_q[DIV_Q_W];
	assign out_side = side_q[DIV_Q_W];
	assign quo = quo_q[DIV_Q_W];
	assign ovf = ovf_q[DIV_Q_W];

endmodule

FILE: rtl/core/apu_sqrt.sv
// Pipelined integer square root, one root bit per stage, with side data carried along.
module apu_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  apu_pkg::side_t                 in_side,
	input  logic [apu_pkg::SQRT_IN_W-1:0]  rad,
	output logic                           out_valid,
	output apu_pkg::side_t                 out_side,
	output logic [apu_pkg::SQRT_OUT_W-1:0] root
);
	import apu_pkg::*;

	localparam int REM_W = SQRT_OUT_W + 2;

	logic                  valid_q [0:SQRT_OUT_W];
	side_t                 side_q  [0:SQRT_OUT_W];
	logic [REM_W-1:0]      rem_q   [0:SQRT_OUT_W];
	logic [SQRT_OUT_W-1:0] root_q  [0:SQRT_OUT_W];
	logic [SQRT_IN_W-1:0]  rad_q   [0:SQRT_OUT_W];

	logic [REM_W-1:0] rem_n [0:SQRT_OUT_W-1];
	logic             bit_n [0:SQRT_OUT_W-1];

	// Bring down two radicand bits and try root*4+1.
	always_comb begin
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] diff;
		for (int k = 0; k < SQRT_OUT_W; k++) begin
			cur = {rem_q[k], rad_q[k][SQRT_IN_W-1:SQRT_IN_W-2]};
			trial = (REM_W+2)'({root_q[k], 2'b01});
			diff = cur - trial;
			bit_n[k] = (cur >= trial);
			rem_n[k] = bit_n[k] ? diff[REM_W-1:0] : cur[REM_W-1:0];
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQRT_OUT_W; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else if (en) begin
			valid_q[0] <= in_valid;
			for (int k = 0; k < SQRT_OUT_W; k++) begin
				valid_q[k+1] <= valid_q[k];
			end
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= '0;
			root_q[0] <= '0;
			rad_q[0] <= rad;
			side_q[0] <= in_side;
			for (int k = 0; k < SQRT_OUT_W; k++) begin
				rem_q[k+1] <= rem_n[k];
				root_q[k+1] <= {root_q[k][SQRT_OUT_W-2:0], bit_n[k]};
				rad_q[k+1] <= {rad_q[k][SQRT_IN_W-3:0], 2'b00};
				side_q[k+1] <= side_q[k];
			end
		end
	end

	assign out_valid = valid_q[SQRT_OUT_W];
	assign out_side = side_q[SQRT_OUT_W];
	assign root = root_q[SQRT_OUT_W];

endmodule

FILE: rtl/core/apu_moment.sv
// Moment stores with read-modify-write pipeline, bias power tracking and reset clearing pass.
module apu_moment (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  apu_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      start,
	input  logic [apu_pkg::IDX_W-1:0] idx,
	input  logic [31:0]               grad,
	input  logic [31:0]               coef,
	input  logic [23:0]               alpha,
	output apu_pkg::mom_t             mom
);
	import apu_pkg::*;

	localparam logic signed [34:0] M_MAX = 35'sh7FFF_FFFF;
	localparam logic signed [34:0] M_MIN = ~M_MAX;

	// Clearing pass and bias powers
	logic             clr_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [23:0]      p1_q, p2_q;
	logic [47:0]      p1_prod, p2_prod;
	logic [23:0]      p1_new, p2_new;
	logic             accept, hazard;

	// Stage 1: accepted element
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0]      grad_s1, coef_s1;
	logic [23:0]      alpha_s1;
	logic [24:0]      c1_s1, c2_s1;

	// Stage 2: moment read data arrives
	logic             valid_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [57:0]      tg_s2;
	logic [63:0]      g2_s2;
	logic [31:0]      coef_s2;
	logic [23:0]      alpha_s2;
	logic [24:0]      c1_s2, c2_s2;

	// Stage 3: products, write back
	logic             valid_s3;
	logic [IDX_W-1:0] idx_s3;
	logic [57:0]      tg_s3;
	logic [56:0]      pm_s3;
	logic [55:0]      pvl_s3, pvh_s3;
	logic [56:0]      pgl_s3, pgh_s3;
	logic [31:0]      coef_s3;
	logic [23:0]      alpha_s3;
	logic [24:0]      c1_s3, c2_s3;

	logic [24:0]        omb1, omb2;
	logic [31:0]        gabs;
	logic signed [57:0] tg_c;
	logic [63:0]        g2_c;
	logic [31:0]        m_rd;
	logic [63:0]        v_rd;
	logic signed [56:0] pm_c;
	logic [55:0]        pvl_c, pvh_c;
	logic [56:0]        pgl_c, pgh_c;
	logic signed [58:0] msum;
	logic signed [34:0] mshift;
	logic [31:0]        m_new;
	logic [89:0]        vsum;
	logic [63:0]        v_new;

	logic             wen, ren;
	logic [IDX_W-1:0] waddr;
	logic [31:0]      wdata_m;
	logic [63:0]      wdata_v;

	// An element may not read a moment that an older element still has to write.
	assign hazard = valid_s1 && ((valid_s2 && (idx_s1 == idx_s2)) ||
		(valid_s3 && (idx_s1 == idx_s3)));
	assign in_ready = !clr_q && en && !hazard;
	assign accept = in_valid && in_ready;

	// A start flag advances the powers before this element uses them.
	assign p1_prod = p1_q * cfg.beta1;
	assign p2_prod = p2_q * cfg.beta2;
	assign p1_new = start ? p1_prod[47:24] : p1_q;
	assign p2_new = start ? p2_prod[47:24] : p2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= POWER_RST;
			p2_q <= POWER_RST;
		end else if (accept) begin
			p1_q <= p1_new;
			p2_q <= p2_new;
		end
	end

	// Zero every entry of both stores after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IDX_W'(NUM_ELEMENTS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			if (!hazard) begin
				valid_s1 <= accept;
			end
			valid_s2 <= valid_s1 && !hazard;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1 capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= idx;
			grad_s1 <= grad;
			coef_s1 <= coef;
			alpha_s1 <= alpha;
			c1_s1 <= ONE_Q24 - {1'b0, p1_new};
			c2_s1 <= ONE_Q24 - {1'b0, p2_new};
		end
	end

	// Gradient terms that do not depend on stored state.
	assign omb1 = ONE_Q24 - {1'b0, cfg.beta1};
	assign omb2 = ONE_Q24 - {1'b0, cfg.beta2};
	assign gabs = grad_s1[31] ? (~grad_s1 + 32'd1) : grad_s1;
	assign tg_c = $signed({1'b0, omb1}) * $signed(grad_s1);
	assign g2_c = gabs * gabs;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= idx_s1;
			tg_s2 <= tg_c;
			g2_s2 <= g2_c;
			coef_s2 <= coef_s1;
			alpha_s2 <= alpha_s1;
			c1_s2 <= c1_s1;
			c2_s2 <= c2_s1;
		end
	end

	// Moment stores.
	assign ren = en && valid_s1 && !hazard;
	assign wen = clr_q || (en && valid_s3);
	assign waddr = clr_q ? clr_addr_q : idx_s3;
	assign wdata_m = clr_q ? 32'd0 : m_new;
	assign wdata_v = clr_q ? 64'd0 : v_new;

	apu_ram #(.WIDTH(32), .DEPTH(NUM_ELEMENTS)) u_first_ram (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata_m),
		.ren   (ren),
		.raddr (idx_s1),
		.rdata (m_rd)
	);

	apu_ram #(.WIDTH(64), .DEPTH(NUM_ELEMENTS)) u_second_ram (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata_v),
		.ren   (ren),
		.raddr (idx_s1),
		.rdata (v_rd)
	);

	// Products on the stored moments and the squared gradient, 64-bit ones in two halves.
	assign pm_c = $signed({1'b0, cfg.beta1}) * $signed(m_rd);
	assign pvl_c = v_rd[31:0] * cfg.beta2;
	assign pvh_c = v_rd[63:32] * cfg.beta2;
	assign pgl_c = g2_s2[31:0] * omb2;
	assign pgh_c = g2_s2[63:32] * omb2;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3 <= idx_s2;
			tg_s3 <= tg_s2;
			pm_s3 <= pm_c;
			pvl_s3 <= pvl_c;
			pvh_s3 <= pvh_c;
			pgl_s3 <= pgl_c;
			pgh_s3 <= pgh_c;
			coef_s3 <= coef_s2;
			alpha_s3 <= alpha_s2;
			c1_s3 <= c1_s2;
			c2_s3 <= c2_s2;
		end
	end

	// Sum, round half up and scale back to the stored formats.
	always_comb begin
		msum = $signed({{2{pm_s3[56]}}, pm_s3}) + $signed({tg_s3[57], tg_s3}) +
			$signed({35'd0, HALF_Q24});
		mshift = msum[58:24];
		if (mshift > M_MAX) begin
			m_new = M_MAX[31:0];
		end else if (mshift < M_MIN) begin
			m_new = M_MIN[31:0];
		end else begin
			m_new = mshift[31:0];
		end
		vsum = 90'(pvl_s3) + (90'(pvh_s3) << 32) + 90'(pgl_s3) + (90'(pgh_s3) << 32) +
			90'(HALF_Q24);
		v_new = vsum[87:24];
	end

	// Moment result register toward the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mom <= '0;
		end else if (en) begin
			mom.valid <= valid_s3;
			mom.m <= m_new;
			mom.v <= v_new;
			mom.c1 <= c1_s3;
			mom.c2 <= c2_s3;
			mom.coef <= coef_s3;
			mom.alpha <= alpha_s3;
			mom.idx <= idx_s3;
		end
	end

endmodule

FILE: rtl/core/adam_parameter_update_core.sv
// Adam parameter update core: moment stores, bias-corrected dividers, square root and step.
// The core takes one element per clock and returns its updated coefficient in order. The
// rate is one element per cycle as long as an element does not repeat the index of one
// of the two elements accepted just before it; such an element waits until the older
// update of the same moment entry is written back to the moment RAMs. After reset the
// core zeroes every entry of both moment stores and accepts no element while it does so;
// configuration writes are taken at any time but are meant to happen only while the
// core is idle. Output back-pressure stalls the whole pipeline only when a finished
// result reaches a full output register.
module adam_parameter_update_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [apu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// element_index, gradient, coefficient, step_size, zero fill
	input  logic [103:0]                       s_axis_tdata,
	// start_iteration
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// updated_coefficient, result_index, zero fill
	output logic [47:0]                        m_axis_tdata
);
	import apu_pkg::*;

	localparam logic signed [50:0] C_MAX = 51'sh7FFF_FFFF;
	localparam logic signed [50:0] C_MIN = ~C_MAX;

	cfg_t  cfg_q;
	logic  en;
	mom_t  mom;

	side_t              mom_side, sq_in_side, sq_side, d3_in_side, d3_side, dv_side;
	logic               dv_valid, sq_valid, d3_valid, dv_ovf, d3_ovf;
	logic [DIV_Q_W-1:0] mq, vq, d3_q;
	logic [31:0]        mabs, mag_c;
	logic [63:0]        mlimit, vhat;
	logic [31:0]        root;
	logic [32:0]        dsum;
	logic [55:0]        prod;
	logic [48:0]        step;
	logic signed [50:0] res_x;
	logic [31:0]        res_c;

	logic             out_valid_q;
	logic [31:0]      out_coef_q;
	logic [IDX_W-1:0] out_idx_q;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beta1 <= BETA1_RST;
			cfg_q.beta2 <= BETA2_RST;
			cfg_q.eps <= EPS_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_BETA1: cfg_q.beta1 <= cfg_data[23:0];
				CFG_BETA2: cfg_q.beta2 <= cfg_data[23:0];
				CFG_EPS:   cfg_q.eps <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// The pipeline stops only when a finished word meets a full output register.
	assign en = !out_valid_q || m_axis_tready || !d3_valid;

	apu_moment u_moment (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.start    (s_axis_tuser),
		.idx      (s_axis_tdata[9:0]),
		.grad     (s_axis_tdata[41:10]),
		.coef     (s_axis_tdata[73:42]),
		.alpha    (s_axis_tdata[97:74]),
		.mom      (mom)
	);

	// Bias corrections: m*2^24/c1 and v*2^24/c2 side by side.
	assign mabs = mom.m[31] ? (~mom.m + 32'd1) : mom.m;
	always_comb begin
		mom_side = '0;
		mom_side.coef = mom.coef;
		mom_side.alpha = mom.alpha;
		mom_side.idx = mom.idx;
		mom_side.neg = mom.m[31];
	end

	apu_div u_div_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mom.valid),
		.in_side   (mom_side),
		.num       ({32'd0, mabs, 24'd0}),
		.den       ({8'd0, mom.c1}),
		.out_valid (),
		.out_side  (),
		.quo       (mq),
		.ovf       ()
	);

	apu_div u_div_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mom.valid),
		.in_side   (mom_side),
		.num       ({mom.v, 24'd0}),
		.den       ({8'd0, mom.c2}),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.quo       (vq),
		.ovf       (dv_ovf)
	);

	// Saturate the corrected moments.
	always_comb begin
		mlimit = dv_side.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		mag_c = (mq > mlimit) ? mlimit[31:0] : mq[31:0];
		vhat = dv_ovf ? '1 : vq;
		sq_in_side = dv_side;
		sq_in_side.mag = mag_c;
	end

	apu_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.in_side   (sq_in_side),
		.rad       (vhat),
		.out_valid (sq_valid),
		.out_side  (sq_side),
		.root      (root)
	);

	// Step = alpha*|m_hat| / ((root + eps) * 2^8).
	always_comb begin
		dsum = {1'b0, root} + {17'd0, cfg_q.eps};
		prod = sq_side.alpha * sq_side.mag;
		d3_in_side = sq_side;
		d3_in_side.dzero = (dsum == 33'd0);
	end

	apu_div u_div_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_side   (d3_in_side),
		.num       ({40'd0, prod[55:8]}),
		.den       (dsum),
		.out_valid (d3_valid),
		.out_side  (d3_side),
		.quo       (d3_q),
		.ovf       (d3_ovf)
	);

	// Apply the step against the sign of m_hat and saturate.
	always_comb begin
		step = (d3_side.dzero || d3_ovf) ? 49'd0 : d3_q[48:0];
		if (d3_side.neg) begin
			res_x = $signed({{19{d3_side.coef[31]}}, d3_side.coef}) + $signed({2'b00, step});
		end else begin
			res_x = $signed({{19{d3_side.coef[31]}}, d3_side.coef}) - $signed({2'b00, step});
		end
		if (res_x > C_MAX) begin
			res_c = C_MAX[31:0];
		end else if (res_x < C_MIN) begin
			res_c = C_MIN[31:0];
		end else begin
			res_c = res_x[31:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= d3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_coef_q <= res_c;
			out_idx_q <= d3_side.idx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'd0, out_idx_q, out_coef_q};

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench of the Adam parameter update core with a built-in bit-exact predictor.
module tb_top;
	import apu_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		bit start;
		bit [9:0] idx;
		bit [31:0] grad;
		bit [31:0] coef;
		bit [23:0] alpha;
	} elem_t;

	typedef struct {
		bit [31:0] coef;
		bit [9:0] idx;
	} upd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	// Predictor state
	bit [23:0] beta1_q, beta2_q;
	bit [15:0] eps_q;
	bit [31:0] mean_store[NUM_ELEMENTS];
	bit [63:0] square_store[NUM_ELEMENTS];
	bit [23:0] pow1_q, pow2_q;

	elem_t pending_words[$];
	upd_t expected_updates[$];
	int send_idle = 0, recv_idle = 0;
	bit recv_hold = 1'b0;
	int fail_count = 0, sent_count = 0, seen_count = 0, start_count = 0;
	int quiet_cycles = 0;

	adam_parameter_update_core i_dut (.*);

	always #4 clk = ~clk;

	function automatic bit [31:0] int_sqrt(bit [63:0] x);
		bit [63:0] rem, res, probe;
		rem = x;
		res = 0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > rem) probe >>= 2;
		while (probe != 0) begin
			if (rem >= res + probe) begin
				rem -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res[31:0];
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Advance moments of one element and work out its new coefficient.
	function automatic upd_t adam_update(elem_t e);
		upd_t u;
		longint g, m, mhat, res;
		bit [63:0] g2, am, q1, v, mag, d, step;
		bit [127:0] acc, vh;
		bit [24:0] c1, c2;
		if (e.start) begin
			pow1_q = (64'(pow1_q) * beta1_q) >> 24;
			pow2_q = (64'(pow2_q) * beta2_q) >> 24;
		end
		g = longint'(signed'(e.grad));
		m = longint'(beta1_q) * longint'(signed'(mean_store[e.idx]))
			+ (longint'(25'h100_0000) - longint'(beta1_q)) * g;
		m = sat32((m + 64'sd8388608) >>> 24);
		mean_store[e.idx] = m[31:0];
		g2 = (g < 0) ? -g : g;
		g2 = g2 * g2;
		acc = 128'(square_store[e.idx]) * 128'(beta2_q)
			+ 128'(g2) * 128'(25'h100_0000 - beta2_q) + 128'(HALF_Q24);
		v = acc[87:24];
		square_store[e.idx] = v;
		c1 = 25'h100_0000 - pow1_q;
		c2 = 25'h100_0000 - pow2_q;
		am = (m < 0) ? -m : m;
		q1 = (am << 24) / c1;
		if (m >= 0) mhat = (q1 > 64'd2147483647) ? 64'sd2147483647 : longint'(q1);
		else mhat = (q1 > 64'd2147483648) ? -64'sd2147483648 : -longint'(q1);
		vh = (128'(v) << 24) / c2;
		if (vh > 128'(64'hFFFF_FFFF_FFFF_FFFF)) vh = 128'(64'hFFFF_FFFF_FFFF_FFFF);
		d = 64'(int_sqrt(vh[63:0])) + eps_q;
		mag = (mhat < 0) ? -mhat : mhat;
		step = (d == 0) ? 64'd0 : (64'(e.alpha) * mag) / (d << 8);
		res = (mhat < 0) ? longint'(signed'(e.coef)) + longint'(step)
			: longint'(signed'(e.coef)) - longint'(step);
		u.coef = sat32(res);
		u.idx = e.idx;
		return u;
	endfunction

	// Driver: offers pending words and predicts each accepted one.
	always @(posedge clk) begin
		bit busy;
		elem_t e;
		busy = s_axis_tvalid;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				e.start = s_axis_tuser;
				e.idx = s_axis_tdata[9:0];
				e.grad = s_axis_tdata[41:10];
				e.coef = s_axis_tdata[73:42];
				e.alpha = s_axis_tdata[97:74];
				expected_updates.push_back(adam_update(e));
				sent_count++;
				start_count += e.start;
				busy = 1'b0;
			end
			if (!busy && pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
				e = pending_words.pop_front();
				s_axis_tdata <= {6'b0, e.alpha, e.coef, e.grad, e.idx};
				s_axis_tuser <= e.start;
				busy = 1'b1;
			end
			s_axis_tvalid <= busy;
		end
	end

	// Monitor: checks each result word and randomizes back-pressure.
	always @(posedge clk) begin
		upd_t want;
		int hold_left;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_count++;
				if (expected_updates.size() == 0) begin
					$display("%0t: unexpected word %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_updates.pop_front();
					if (m_axis_tdata[31:0] !== want.coef)
						$display("%0t: coefficient expected %h actual %h", $time, want.coef,
							m_axis_tdata[31:0]);
					if (m_axis_tdata[41:32] !== want.idx)
						$display("%0t: index expected %0d actual %0d", $time, want.idx,
							m_axis_tdata[41:32]);
					if (m_axis_tdata[31:0] !== want.coef || m_axis_tdata[41:32] !== want.idx)
						fail_count++;
				end
			end
			if (recv_hold && hold_left == 0) hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0) recv_hold = 1'b0;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end else begin
			hold_left = 0;
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		case (index)
			CFG_BETA1: beta1_q = value;
			CFG_BETA2: beta2_q = value;
			CFG_EPS: eps_q = value[15:0];
			default: ;
		endcase
	endtask

	task automatic cfg_all(logic [23:0] b1, logic [23:0] b2, logic [15:0] eps);
		cfg_write(CFG_BETA1, b1);
		cfg_write(CFG_BETA2, b2);
		cfg_write(CFG_EPS, {8'hA5, eps});
		cfg_write(CFG_SPARE, $urandom);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// Sender pause until every queued word has come back, then let the pipe drain.
	task automatic wait_idle();
		while (pending_words.size() > 0 || s_axis_tvalid || expected_updates.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_word(bit st, bit [9:0] idx, bit [31:0] g, bit [31:0] c, bit [23:0] a);
		elem_t e;
		e.start = st;
		e.idx = idx;
		e.grad = g;
		e.coef = c;
		e.alpha = a;
		pending_words.push_back(e);
	endtask

	// Random words: half of them on clustered indices so that repeats of recent entries occur.
	task automatic push_random(int count);
		bit [31:0] g;
		bit [9:0] idx;
		repeat (count) begin
			case ($urandom_range(3))
				0: g = $urandom;
				1: g = $urandom >>> $urandom_range(31);
				2: g = {{16{$urandom_range(1) == 1}}, 16'($urandom)};
				default: g = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			endcase
			idx = $urandom_range(1) ? 10'($urandom_range(7)) : 10'($urandom);
			push_word($urandom_range(31) == 0, idx, g, $urandom, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_ELEMENTS; i++) begin
			mean_store[i] = '0;
			square_store[i] = '0;
		end
		beta1_q = BETA1_RST;
		beta2_q = BETA2_RST;
		eps_q = EPS_RST;
		pow1_q = POWER_RST;
		pow2_q = POWER_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at reset settings, first ones before any start.
		send_idle = 7;
		recv_idle = 68;
		push_word(1'b0, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
		push_word(1'b0, 10'd1023, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
		push_word(1'b0, 10'd5, 32'h0001_0000, 32'h0, 24'h0);
		push_word(1'b1, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
		push_word(1'b0, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
		push_word(1'b0, 10'd0, 32'h0, 32'h1234_5678, 24'h80_0000);
		push_word(1'b1, 10'd1023, 32'hFFFF_FFFF, 32'h0, 24'h00_0001);
		push_word(1'b1, 10'd7, 32'h0000_0001, 32'hFFFF_0000, 24'h10_0000);
		push_word(1'b0, 10'd512, 32'h5555_5555, 32'hAAAA_AAAA, 24'hAA_AAAA);
		push_word(1'b0, 10'd341, 32'hAAAA_AAAA, 32'h5555_5555, 24'h55_5555);
		wait_idle();

		// Zero decays and epsilon; untouched entries with zero gradient take no step at all.
		cfg_all(24'd0, 24'd0, 16'd0);
		push_word(1'b0, 10'd900, 32'h0, 32'h0BAD_F00D, 24'hFF_FFFF);
		push_word(1'b1, 10'd901, 32'h0, 32'h8000_0000, 24'hFF_FFFF);
		push_word(1'b0, 10'd902, 32'h0001_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
		push_random(330);
		wait_idle();

		// Largest decays and epsilon, sender idles more than receiver.
		cfg_all(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
		send_idle = 68;
		recv_idle = 7;
		push_random(330);
		wait_idle();

		// Default-like decays, no idling, one long receiver hold while words keep coming.
		cfg_all(BETA1_RST, BETA2_RST, EPS_RST);
		send_idle = 0;
		recv_idle = 0;
		push_random(330);
		recv_hold = 1'b1;
		wait_idle();

		// Random settings to finish.
		cfg_all($urandom, $urandom, $urandom);
		send_idle = 7;
		recv_idle = 68;
		push_random(330);
		wait_idle();

		$display("Covered %0d words with %0d iteration starts, %0d results checked,", sent_count,
			start_count, seen_count);
		$display("over extreme, reset and random decay and epsilon settings with back-pressure.");
		if (fail_count == 0 && expected_updates.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
